// ===== rtl/core/hrbd_pkg.sv =====
// shared constants and types of the http response body deframer
`timescale 1ns / 1ps
package hrbd_pkg;

    // match pattern for the length header line
    localparam int unsigned PAT_LEN = 16;
    localparam int unsigned MP_W    = 5;
    localparam logic [7:0] PATTERN [PAT_LEN] = '{
        8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
        8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
    };

    // character codes
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CASE_GAP  = 8'h20;
    localparam logic [7:0] DEC_LIMIT = 8'h3a;
    localparam logic [31:0] HEX_LOW_BIAS  = 32'd48;
    localparam logic [31:0] HEX_HIGH_BIAS = 32'd87;

    // header and chunk line limits
    localparam logic [2:0] HDR_BREAKS    = 3'd4;
    localparam logic [1:0] CHUNK_BREAKS  = 2'd2;
    localparam logic [3:0] MAX_LENGTH_DIGITS = 4'd9;
    localparam logic [31:0] CHUNK_TRAILER = 32'd2;
    localparam logic [31:0] CHUNK_SAT_LIM = 32'hffff_fffd;

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // progress of the length header search
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_DIGITS = 2'd1,
        PH_CLOSED = 2'd2
    } t_phase;

    // one classified input word
    typedef struct packed {
        logic               begin_req;
        logic               link_closed;
        logic [7:0]         rx_byte;
        logic               is_break;
        logic               is_digit;
        logic [3:0]         digit;
        logic [31:0]        hex_val;
        logic [PAT_LEN-1:0] pat_hit;
    } t_item;

endpackage

// ===== rtl/core/hrbd_front.sv =====
// front end: classifies each received byte before queueing
`timescale 1ns / 1ps
module hrbd_front (
    input  logic           i_begin_req,
    input  logic           i_link_closed,
    input  logic [7:0]     i_rx_byte,
    output hrbd_pkg::t_item o_item
);
    import hrbd_pkg::*;

    logic [7:0]  folded;

    // case fold for the hex digit rule
    always_comb begin
        if (i_rx_byte >= CH_UP_A && i_rx_byte <= CH_UP_Z) begin
            folded = i_rx_byte + CASE_GAP;
        end else begin
            folded = i_rx_byte;
        end
    end

    // per byte classification
    always_comb begin
        o_item.begin_req   = i_begin_req;
        o_item.link_closed = i_link_closed;
        o_item.rx_byte     = i_rx_byte;
        o_item.is_break    = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
        o_item.is_digit    = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        o_item.digit       = i_rx_byte[3:0];
        if (folded < DEC_LIMIT) begin
            o_item.hex_val = {24'd0, folded} - HEX_LOW_BIAS;
        end else begin
            o_item.hex_val = {24'd0, folded} - HEX_HIGH_BIAS;
        end
        for (int i = 0; i < PAT_LEN; i++) begin
            o_item.pat_hit[i] = (i_rx_byte == PATTERN[i]);
        end
    end

endmodule

// ===== rtl/core/hrbd_queue.sv =====
// short queue of classified words between front and back
`timescale 1ns / 1ps
module hrbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrbd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_not_empty,
    output hrbd_pkg::t_item o_item
);
    import hrbd_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QCNT_W-1:0]  n_count;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/hrbd_back.sv =====
// back end: header, length and chunk parsing with the result register
`timescale 1ns / 1ps
module hrbd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  hrbd_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_body_valid,
    output logic [7:0]      o_body_byte,
    output logic            o_finished,
    output logic            o_success
);
    import hrbd_pkg::*;

    // parse state
    logic            r_active,  n_active,  s_active;
    logic [2:0]      r_hbr,     n_hbr,     s_hbr;
    logic [MP_W-1:0] r_mp,      n_mp,      s_mp;
    t_phase          r_phase,   n_phase,   s_phase;
    logic [3:0]      r_ldc,     n_ldc,     s_ldc;
    logic [31:0]     r_cl,      n_cl,      s_cl;
    logic [31:0]     r_bc,      n_bc,      s_bc;
    logic [31:0]     r_cr,      n_cr,      s_cr;
    logic [1:0]      r_cbr,     n_cbr,     s_cbr;
    logic [31:0]     r_acc,     n_acc,     s_acc;

    // result register
    logic            r_out_valid;
    logic            r_body_valid, n_body_valid;
    logic [7:0]      r_body_byte,  n_body_byte;
    logic            r_finished,   n_finished;
    logic            r_success,    n_success;

    logic [31:0]     bc_inc;
    logic [31:0]     chunk_val;

    assign o_pop        = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_body_valid = r_body_valid;
    assign o_body_byte  = r_body_byte;
    assign o_finished   = r_finished;
    assign o_success    = r_success;

    // state seen by this word, after a begin clears it
    always_comb begin
        if (i_item.begin_req) begin
            s_active = 1'b1;
            s_hbr    = '0;
            s_mp     = '0;
            s_phase  = PH_SEARCH;
            s_ldc    = '0;
            s_cl     = '0;
            s_bc     = '0;
            s_cr     = '0;
            s_cbr    = '0;
            s_acc    = '0;
        end else begin
            s_active = r_active;
            s_hbr    = r_hbr;
            s_mp     = r_mp;
            s_phase  = r_phase;
            s_ldc    = r_ldc;
            s_cl     = r_cl;
            s_bc     = r_bc;
            s_cr     = r_cr;
            s_cbr    = r_cbr;
            s_acc    = r_acc;
        end
    end

    // parse step for one word
    always_comb begin
        n_active     = s_active;
        n_hbr        = s_hbr;
        n_mp         = s_mp;
        n_phase      = s_phase;
        n_ldc        = s_ldc;
        n_cl         = s_cl;
        n_bc         = s_bc;
        n_cr         = s_cr;
        n_cbr        = s_cbr;
        n_acc        = s_acc;
        n_body_valid = 1'b0;
        n_body_byte  = '0;
        n_finished   = 1'b0;
        n_success    = 1'b0;
        bc_inc       = s_bc + 32'd1;
        chunk_val    = s_acc;

        if (s_active && i_item.link_closed) begin
            n_active   = 1'b0;
            n_finished = 1'b1;
        end else if (s_active) begin
            if (s_hbr < HDR_BREAKS) begin
                // header: break run and length line search
                n_hbr = i_item.is_break ? s_hbr + 3'd1 : 3'd0;
                unique case (s_phase)
                    PH_SEARCH: begin
                        if (i_item.pat_hit[s_mp[MP_W-2:0]]) begin
                            n_mp = s_mp + MP_W'(1);
                        end else begin
                            n_mp = {{(MP_W-1){1'b0}}, i_item.pat_hit[0]};
                        end
                        if (n_mp == MP_W'(PAT_LEN)) begin
                            n_phase = PH_DIGITS;
                            n_ldc   = '0;
                            n_cl    = '0;
                        end
                    end
                    PH_DIGITS: begin
                        if (i_item.is_digit) begin
                            if (s_ldc < MAX_LENGTH_DIGITS) begin
                                n_cl  = (s_cl << 3) + (s_cl << 1)
                                        + {28'd0, i_item.digit};
                                n_ldc = s_ldc + 4'd1;
                            end
                        end else begin
                            n_phase = PH_CLOSED;
                        end
                    end
                    default: ;
                endcase
                if (n_hbr == HDR_BREAKS) begin
                    if (n_phase != PH_SEARCH && n_cl == '0) begin
                        n_active   = 1'b0;
                        n_finished = 1'b1;
                        n_success  = 1'b1;
                    end else if (n_cl != '0) begin
                        n_bc = '0;
                    end else begin
                        n_cr  = '0;
                        n_cbr = '0;
                        n_acc = '0;
                    end
                end
            end else if (s_cl != '0) begin
                // length mode body
                n_body_valid = 1'b1;
                n_body_byte  = i_item.rx_byte;
                n_bc         = bc_inc;
                if (bc_inc >= s_cl) begin
                    n_active   = 1'b0;
                    n_finished = 1'b1;
                    n_success  = 1'b1;
                end
            end else if (s_cr == '0) begin
                // chunk size line
                if (i_item.is_break) begin
                    n_cbr = s_cbr + 2'd1;
                end else begin
                    n_cbr     = '0;
                    chunk_val = (s_acc << 4) | i_item.hex_val;
                    n_acc     = chunk_val;
                end
                if (n_cbr >= CHUNK_BREAKS) begin
                    n_cbr = '0;
                    n_acc = '0;
                    if (chunk_val == '0) begin
                        n_active   = 1'b0;
                        n_finished = 1'b1;
                        n_success  = 1'b1;
                    end else if (chunk_val > CHUNK_SAT_LIM) begin
                        n_cr = '1;
                    end else begin
                        n_cr = chunk_val + CHUNK_TRAILER;
                    end
                end
            end else begin
                // chunk data, trailing line break dropped
                if (s_cr > CHUNK_TRAILER) begin
                    n_body_valid = 1'b1;
                    n_body_byte  = i_item.rx_byte;
                end
                n_cr = s_cr - 32'd1;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_hbr       <= '0;
            r_mp        <= '0;
            r_phase     <= PH_SEARCH;
            r_ldc       <= '0;
            r_cl        <= '0;
            r_bc        <= '0;
            r_cr        <= '0;
            r_cbr       <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active    <= n_active;
                r_hbr       <= n_hbr;
                r_mp        <= n_mp;
                r_phase     <= n_phase;
                r_ldc       <= n_ldc;
                r_cl        <= n_cl;
                r_bc        <= n_bc;
                r_cr        <= n_cr;
                r_cbr       <= n_cbr;
                r_acc       <= n_acc;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_body_valid <= n_body_valid;
            r_body_byte  <= n_body_byte;
            r_finished   <= n_finished;
            r_success    <= n_success;
        end
    end

endmodule

// ===== rtl/core/http_response_body_deframer_core.sv =====
// top level of the http response body deframer
`timescale 1ns / 1ps
// Takes one response byte per input word and returns exactly one result word
// per input word: a body byte with its flag, and an end flag with a success
// flag. Header bytes are dropped, the body is framed by Content-Length or by
// chunked coding, and a begin flag rearms the parser. A front end classifies
// each byte and writes it into a four entry queue; the back end parses one
// queued word per cycle into a result register while the receiver does not
// stall it. Sustained rate is one word per cycle when neither side stalls; a
// result passes the queue write and then the result register.
module http_response_body_deframer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_begin_req,
    input  logic       i_link_closed,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_body_valid,
    output logic [7:0] o_body_byte,
    output logic       o_finished,
    output logic       o_success
);
    import hrbd_pkg::*;

    t_item cls_item;
    t_item q_item;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  q_push;

    assign o_in_stall = q_full;
    assign q_push     = i_in_valid && !q_full;

    // byte classification
    hrbd_front u_front (
        .i_begin_req   (i_begin_req),
        .i_link_closed (i_link_closed),
        .i_rx_byte     (i_rx_byte),
        .o_item        (cls_item)
    );

    // decoupling queue
    hrbd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_item      (cls_item),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_item      (q_item)
    );

    // parser and result register
    hrbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_not_empty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_body_valid (o_body_valid),
        .o_body_byte  (o_body_byte),
        .o_finished   (o_finished),
        .o_success    (o_success)
    );

endmodule

// ===== tb/tb_top.sv =====
// testbench of the http response body deframer core, with its own parser model
`timescale 1ns / 1ps
module tb_top;
    import hrbd_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_begin_req;
    logic       i_link_closed;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_body_valid;
    logic [7:0] o_body_byte;
    logic       o_finished;
    logic       o_success;

    // one result word
    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       finished;
        logic       success;
    } t_body_word;

    // one input word, with a typed-in result where one is given
    typedef struct packed {
        logic       rearm;
        logic       closed;
        logic [7:0] data;
        logic       typed;
        logic       want_valid;
        logic [7:0] want_byte;
        logic       want_fin;
        logic       want_ok;
    } t_stim;

    // how a generated response frames its body
    typedef enum logic [1:0] {
        FRAME_LENGTH,
        FRAME_EMPTY,
        FRAME_CHUNKED
    } t_frame_kind;

    // directed words: idle, begin with close, a two byte chunk, end, then idle again
    localparam int DIRECTED_N = 18;
    localparam t_stim DIRECTED_ROWS [DIRECTED_N] = '{
        '{1'b0, 1'b0, 8'hff,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // idle byte dropped
        '{1'b0, 1'b1, 8'h00,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0},  // close while idle dropped
        '{1'b1, 1'b1, 8'h41,  1'b1, 1'b0, 8'h00, 1'b1, 1'b0},  // begin with close fails
        '{1'b1, 1'b0, CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // empty header, chunked
        '{1'b0, 1'b0, 8'h32,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // chunk size 2
        '{1'b0, 1'b0, CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, 8'h00,  1'b1, 1'b1, 8'h00, 1'b0, 1'b0},  // lowest data byte
        '{1'b0, 1'b0, 8'hff,  1'b1, 1'b1, 8'hff, 1'b0, 1'b0},  // highest data byte
        '{1'b0, 1'b0, CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},  // chunk trailer dropped
        '{1'b0, 1'b0, CH_LF,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_ZERO, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}, // last chunk
        '{1'b0, 1'b0, CH_CR,  1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 1'b0, CH_LF,  1'b1, 1'b0, 8'h00, 1'b1, 1'b1},  // response complete
        '{1'b0, 1'b0, 8'h35,  1'b1, 1'b0, 8'h00, 1'b0, 1'b0}   // ignored after the end
    };

    // parser model state
    logic        pm_active;
    logic [2:0]  pm_hdr_breaks;
    logic [4:0]  pm_pat_pos;
    t_phase      pm_len_phase;
    logic [3:0]  pm_len_digits;
    logic [31:0] pm_content_len;
    logic [31:0] pm_body_seen;
    logic [31:0] pm_chunk_left;
    logic [1:0]  pm_line_breaks;
    logic [31:0] pm_hex_acc;

    t_stim       stim_q [$];
    t_stim       resp_q [$];
    t_body_word  expected_words [$];
    t_body_word  model_word;
    t_body_word  want_word;
    logic        cur_typed;
    t_body_word  cur_word;
    t_stim       row;

    int unsigned accepted_items;
    int unsigned random_items;
    int unsigned checked_words;
    int unsigned body_bytes;
    int unsigned good_ends;
    int unsigned failed_ends;
    int unsigned mismatches;
    int unsigned gap;
    int unsigned calm_items;
    int unsigned calm_cycles;
    int unsigned hold_cycles;
    int unsigned roll;
    int unsigned target;

    http_response_body_deframer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_begin_req   (i_begin_req),
        .i_link_closed (i_link_closed),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_body_valid  (o_body_valid),
        .o_body_byte   (o_body_byte),
        .o_finished    (o_finished),
        .o_success     (o_success)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // clear every parse register
    function void clear_parse();
        pm_active      = 1'b0;
        pm_hdr_breaks  = '0;
        pm_pat_pos     = '0;
        pm_len_phase   = PH_SEARCH;
        pm_len_digits  = '0;
        pm_content_len = '0;
        pm_body_seen   = '0;
        pm_chunk_left  = '0;
        pm_line_breaks = '0;
        pm_hex_acc     = '0;
    endfunction

    // parse one accepted word and work out its result word
    function void deframe_byte(input logic rearm, input logic closed, input logic [7:0] b,
                               output t_body_word w);
        logic        is_brk;
        logic [31:0] fold;
        logic [31:0] nibble;
        logic [31:0] size;
        w = '0;
        is_brk = (b == CH_CR) || (b == CH_LF);
        if (rearm) begin
            clear_parse();
            pm_active = 1'b1;
        end
        if (pm_active && closed) begin
            pm_active  = 1'b0;
            w.finished = 1'b1;
        end else if (pm_active) begin
            if (pm_hdr_breaks < HDR_BREAKS) begin
                // header: break run and length header search
                pm_hdr_breaks = is_brk ? pm_hdr_breaks + 3'd1 : 3'd0;
                case (pm_len_phase)
                    PH_SEARCH: begin
                        if (pm_pat_pos < PAT_LEN && b == PATTERN[pm_pat_pos])
                            pm_pat_pos = pm_pat_pos + 5'd1;
                        else
                            pm_pat_pos = (b == PATTERN[0]) ? 5'd1 : 5'd0;
                        if (pm_pat_pos >= PAT_LEN) begin
                            pm_len_phase   = PH_DIGITS;
                            pm_len_digits  = '0;
                            pm_content_len = '0;
                        end
                    end
                    PH_DIGITS: begin
                        if (b >= CH_ZERO && b <= CH_NINE) begin
                            if (pm_len_digits < MAX_LENGTH_DIGITS) begin
                                pm_content_len = pm_content_len * 32'd10 + 32'(b - CH_ZERO);
                                pm_len_digits  = pm_len_digits + 4'd1;
                            end
                        end else begin
                            pm_len_phase = PH_CLOSED;
                        end
                    end
                    default: ;
                endcase
                if (pm_hdr_breaks == HDR_BREAKS) begin
                    if (pm_len_phase != PH_SEARCH && pm_content_len == 0) begin
                        pm_active  = 1'b0;
                        w.finished = 1'b1;
                        w.success  = 1'b1;
                    end else if (pm_content_len != 0) begin
                        pm_body_seen = '0;
                    end else begin
                        pm_chunk_left  = '0;
                        pm_line_breaks = '0;
                        pm_hex_acc     = '0;
                    end
                end
            end else if (pm_content_len != 0) begin
                // length framed body
                w.body_valid = 1'b1;
                w.body_byte  = b;
                pm_body_seen = pm_body_seen + 32'd1;
                if (pm_body_seen >= pm_content_len) begin
                    pm_active  = 1'b0;
                    w.finished = 1'b1;
                    w.success  = 1'b1;
                end
            end else if (pm_chunk_left == 0) begin
                // chunk size line
                if (is_brk) begin
                    pm_line_breaks = pm_line_breaks + 2'd1;
                end else begin
                    pm_line_breaks = '0;
                    fold = {24'd0, b};
                    if (b >= CH_UP_A && b <= CH_UP_Z)
                        fold = fold + 32'(CASE_GAP);
                    nibble = (fold < 32'(DEC_LIMIT)) ? fold - HEX_LOW_BIAS
                                                     : fold - HEX_HIGH_BIAS;
                    pm_hex_acc = (pm_hex_acc << 4) | nibble;
                end
                if (pm_line_breaks >= CHUNK_BREAKS) begin
                    size           = pm_hex_acc;
                    pm_line_breaks = '0;
                    pm_hex_acc     = '0;
                    if (size == 0) begin
                        pm_active  = 1'b0;
                        w.finished = 1'b1;
                        w.success  = 1'b1;
                    end else begin
                        pm_chunk_left = (size > CHUNK_SAT_LIM) ? '1 : size + CHUNK_TRAILER;
                    end
                end
            end else begin
                // chunk data, then its two trailer bytes dropped
                if (pm_chunk_left > CHUNK_TRAILER) begin
                    w.body_valid = 1'b1;
                    w.body_byte  = b;
                end
                pm_chunk_left = pm_chunk_left - 32'd1;
            end
        end
    endfunction

    // response assembly helpers
    task automatic add_byte(input logic [7:0] b);
        t_stim s;
        s      = '0;
        s.data = b;
        resp_q.push_back(s);
    endtask

    task automatic add_text(input string t);
        int i;
        for (i = 0; i < t.len(); i++)
            add_byte(t.getc(i));
    endtask

    task automatic add_breaks(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    // one random response, well formed, broken or noise, appended to the stimulus
    task automatic build_response();
        int unsigned kind;
        int unsigned n;
        int unsigned i;
        int unsigned k;
        int unsigned cut;
        int unsigned pick;
        bit          broken;
        bit          huge;
        t_frame_kind frame;
        string       digits;
        string       hex;
        string       hdr [$];
        t_stim       s;
        logic [7:0]  ch;
        resp_q.delete();
        kind   = $urandom_range(0, 99);
        broken = (kind >= 80 && kind < 92);
        huge   = broken && ($urandom_range(0, 2) == 0);
        if (kind >= 92) begin
            // noise: random flags and bytes, rich in breaks
            n = $urandom_range(4, 30);
            for (i = 0; i < n; i++) begin
                s        = '0;
                s.rearm  = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0);
                s.closed = ($urandom_range(0, 7) == 0);
                if ($urandom_range(0, 2) == 0)
                    s.data = $urandom_range(0, 1) ? CH_CR : CH_LF;
                else
                    s.data = $urandom_range(0, 255);
                resp_q.push_back(s);
            end
        end else begin
            if (kind < 40)
                frame = FRAME_LENGTH;
            else if (kind < 50)
                frame = FRAME_EMPTY;
            else if (kind < 80)
                frame = FRAME_CHUNKED;
            else
                frame = t_frame_kind'($urandom_range(0, 2));
            n = 0;
            digits = "";
            // header lines
            if ($urandom_range(0, 1))
                hdr.push_back("HTTP/1.1 200 OK");
            k = $urandom_range(0, 2);
            for (i = 0; i < k; i++) begin
                hex = "X-";
                n = $urandom_range(1, 5);
                while (n > 0) begin
                    hex = {hex, string'(8'($urandom_range(8'h61, 8'h7a)))};
                    n--;
                end
                hdr.push_back({hex, ": v"});
            end
            n = 0;
            if (frame == FRAME_LENGTH) begin
                pick = $urandom_range(0, 19);
                if (huge && pick < 8) begin
                    digits = (pick < 4) ? "999999999" : "4294967295";
                    n = 300;
                end else begin
                    n = (pick < 18) ? $urandom_range(1, 40) : $urandom_range(41, 300);
                    digits = $sformatf("%0d", n);
                    // digits past the ninth are dropped
                    if ($urandom_range(0, 7) == 0) begin
                        while (digits.len() < 9)
                            digits = {"0", digits};
                        digits = {digits, $sformatf("%0d", $urandom_range(0, 99))};
                    end
                end
            end else if (frame == FRAME_EMPTY) begin
                case ($urandom_range(0, 3))
                    0: digits = "0";
                    1: digits = "000";
                    2: digits = "000000000000";
                    default: digits = "";
                endcase
            end
            if (frame != FRAME_CHUNKED) begin
                if ($urandom_range(0, 3) == 0)
                    digits = {digits, ($urandom_range(0, 1) ? ";q=7" : " 12")};
                hdr.insert($urandom_range(0, hdr.size()), {"Content-Length: ", digits});
            end else if ($urandom_range(0, 2) == 0) begin
                // near misses of the length header
                case ($urandom_range(0, 2))
                    0: hdr.insert(0, "content-length: 5");
                    1: hdr.insert(0, "Content-Length:5");
                    default: hdr.insert(0, "Content-Lengt: 3");
                endcase
            end
            for (i = 0; i < hdr.size(); i++) begin
                if (i != 0)
                    add_breaks($urandom_range(1, 3));
                add_text(hdr[i]);
            end
            add_breaks(4);
            // body
            if (frame == FRAME_LENGTH) begin
                for (i = 0; i < n; i++)
                    add_byte($urandom_range(0, 255));
            end else if (frame == FRAME_CHUNKED) begin
                k = $urandom_range(1, 3);
                while (k > 0) begin
                    if (huge && $urandom_range(0, 1)) begin
                        case ($urandom_range(0, 3))
                            0: hex = "FFFFFFFF";
                            1: hex = "fffffffe";
                            2: hex = "FfFfFfFd";
                            default: hex = "100000003";
                        endcase
                        n = 300;
                    end else begin
                        n = $urandom_range(1, 24);
                        hex = $sformatf("%0h", n);
                        for (i = 0; i < hex.len(); i++) begin
                            ch = hex.getc(i);
                            if (ch >= 8'h61 && $urandom_range(0, 1))
                                hex.putc(i, ch - CASE_GAP);
                        end
                        pick = $urandom_range(0, 2);
                        while (pick > 0) begin
                            hex = {"0", hex};
                            pick--;
                        end
                    end
                    add_text(hex);
                    add_breaks(2);
                    for (i = 0; i < n; i++)
                        add_byte($urandom_range(0, 255));
                    if ($urandom_range(0, 3) == 0) begin
                        add_byte($urandom_range(0, 255));
                        add_byte($urandom_range(0, 255));
                    end else begin
                        add_text("\r\n");
                    end
                    k--;
                end
                add_text($urandom_range(0, 1) ? "0" : "00");
                add_breaks(2);
            end
            // stray bytes after the end are ignored
            if ($urandom_range(0, 3) == 0)
                add_breaks($urandom_range(1, 2));
            resp_q[0].rearm = 1'b1;
        end
        if (broken && resp_q.size() > 1) begin
            cut = $urandom_range(1, resp_q.size() - 1);
            while (resp_q.size() > cut)
                void'(resp_q.pop_back());
            if ($urandom_range(0, 2) != 0) begin
                s        = '0;
                s.closed = 1'b1;
                s.data   = $urandom_range(0, 255);
                resp_q.push_back(s);
            end
        end
        random_items += resp_q.size();
        foreach (resp_q[i])
            stim_q.push_back(resp_q[i]);
    endtask

    // monitor: predict on input handshake, check on output handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                deframe_byte(i_begin_req, i_link_closed, i_rx_byte, model_word);
                expected_words.push_back(cur_typed ? cur_word : model_word);
                accepted_items++;
            end
            if (o_out_valid && !i_out_stall) begin
                checked_words++;
                if (o_body_valid)
                    body_bytes++;
                if (o_finished && o_success)
                    good_ends++;
                else if (o_finished)
                    failed_ends++;
                if (expected_words.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with none expected: %s %0b %02h %0b %0b",
                             $time, "valid byte fin ok", o_body_valid, o_body_byte,
                             o_finished, o_success);
                end else begin
                    want_word = expected_words.pop_front();
                    if (o_body_valid !== want_word.body_valid) begin
                        mismatches++;
                        $display("%0t: body_valid expected %0b got %0b",
                                 $time, want_word.body_valid, o_body_valid);
                    end
                    if (o_body_byte !== want_word.body_byte) begin
                        mismatches++;
                        $display("%0t: body_byte expected %02h got %02h",
                                 $time, want_word.body_byte, o_body_byte);
                    end
                    if (o_finished !== want_word.finished) begin
                        mismatches++;
                        $display("%0t: finished expected %0b got %0b",
                                 $time, want_word.finished, o_finished);
                    end
                    if (o_success !== want_word.success) begin
                        mismatches++;
                        $display("%0t: success expected %0b got %0b",
                                 $time, want_word.success, o_success);
                    end
                end
            end
        end
    end

    // receiver stall: short random stalls, some long holds, some calm stretches
    initial begin
        i_out_stall = 1'b0;
        calm_cycles = 0;
        hold_cycles = 0;
        forever begin
            @(negedge i_clk);
            if (calm_cycles > 0) begin
                calm_cycles--;
                i_out_stall = 1'b0;
            end else if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall = 1'b1;
            end else begin
                roll = $urandom_range(0, 199);
                if (roll < 2) begin
                    calm_cycles = $urandom_range(30, 150);
                    i_out_stall = 1'b0;
                end else if (roll < 6) begin
                    hold_cycles = $urandom_range(8, 30);
                    i_out_stall = 1'b1;
                end else begin
                    i_out_stall = (roll < 60);
                end
            end
        end
    end

    // hang guard
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // sender: reset, then the directed table, then random responses
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_begin_req    = 1'b0;
        i_link_closed  = 1'b0;
        i_rx_byte      = 8'h00;
        cur_typed      = 1'b0;
        cur_word       = '0;
        accepted_items = 0;
        random_items   = 0;
        checked_words  = 0;
        body_bytes     = 0;
        good_ends      = 0;
        failed_ends    = 0;
        mismatches     = 0;
        calm_items     = 0;
        clear_parse();

        for (int i = 0; i < DIRECTED_N; i++)
            stim_q.push_back(DIRECTED_ROWS[i]);
        while (random_items < 1500)
            build_response();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            // gap before the word
            if (calm_items > 0) begin
                calm_items--;
                gap = 0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    calm_items = $urandom_range(20, 80);
                    gap = 0;
                end else if (roll < 50) begin
                    gap = 0;
                end else if (roll < 92) begin
                    gap = $urandom_range(1, 3);
                end else begin
                    gap = $urandom_range(6, 25);
                end
            end
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_begin_req   = row.rearm;
            i_link_closed = row.closed;
            i_rx_byte     = row.data;
            cur_typed     = row.typed;
            cur_word      = '{row.want_valid, row.want_byte, row.want_fin, row.want_ok};
            i_in_valid    = 1'b1;
            target        = accepted_items + 1;
            do @(negedge i_clk); while (accepted_items != target);
        end
        i_in_valid = 1'b0;

        // drain, then watch on for any result word unasked for
        while (expected_words.size() != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("Run covered %0d input words (%0d directed) and %0d result words,",
                 accepted_items, DIRECTED_N, checked_words);
        $display("with %0d body bytes, %0d completed and %0d failed responses; %0d mismatches.",
                 body_bytes, good_ends, failed_ends, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
